// File: rtl/ealu_pkg.sv
`default_nettype none

package ealu_pkg;

	// command codes
	localparam logic [4:0] CMD_ADD   = 5'd0;
	localparam logic [4:0] CMD_ADC   = 5'd1;
	localparam logic [4:0] CMD_SUB   = 5'd2;
	localparam logic [4:0] CMD_SBC   = 5'd3;
	localparam logic [4:0] CMD_AND   = 5'd4;
	localparam logic [4:0] CMD_XOR   = 5'd5;
	localparam logic [4:0] CMD_OR    = 5'd6;
	localparam logic [4:0] CMD_CP    = 5'd7;
	localparam logic [4:0] CMD_INC8  = 5'd8;
	localparam logic [4:0] CMD_DEC8  = 5'd9;
	localparam logic [4:0] CMD_INC16 = 5'd10;
	localparam logic [4:0] CMD_DEC16 = 5'd11;
	localparam logic [4:0] CMD_DAA   = 5'd12;
	localparam logic [4:0] CMD_SCF   = 5'd13;
	localparam logic [4:0] CMD_CPL   = 5'd14;
	localparam logic [4:0] CMD_CCF   = 5'd15;
	localparam logic [4:0] CMD_ADDHL = 5'd16;
	localparam logic [4:0] CMD_ADDSP = 5'd17;

	// decimal adjust constants
	localparam logic [7:0] DAA_HI_ADJ = 8'h60;
	localparam logic [7:0] DAA_LO_ADJ = 8'h06;
	localparam logic [7:0] BCD_MAX    = 8'h99;
	localparam logic [3:0] DIGIT_MAX  = 4'h9;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		logic [4:0]        cmd;
		logic [7:0]        byte_operand;
		logic [15:0]       word_base;
		logic [15:0]       word_operand;
		logic signed [7:0] signed_offset;
	} req_t;

	typedef struct packed {
		logic [7:0]  accumulator_out;
		logic [7:0]  byte_result;
		logic [15:0] word_result;
		logic        zero_flag;
		logic        subtract_flag;
		logic        half_carry_flag;
		logic        carry_flag;
	} rsp_t;

endpackage

`default_nettype wire

// File: rtl/eight_bit_alu_with_flags.sv
`default_nettype none

// eight-bit alu with z, n, h and c flags. it holds the accumulator and the
// four flags; each item on req carries a command code and its operands, and
// each item yields exactly one item on rsp with the new accumulator, the
// inc/dec byte result, the 16-bit result and the new flags. unused result
// fields read zero, and an unknown command code changes nothing. one item
// per cycle is taken sustained while rsp is not stalled; an accepted item
// passes through the input register, then the result register, before
// rsp_valid rises for it. a stalled rsp holds one item in each register
// and then drops req_ready. the rate is set by the accumulator/flag
// feedback loop, which closes through the single combinational alu pass
// between those two registers. reset clears the accumulator and all flags.
module eight_bit_alu_with_flags (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ealu_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ealu_pkg::rsp_t  rsp
);
	import ealu_pkg::*;

	// input stage
	logic   valid_s1;
	req_t   req_s1;
	// result stage
	logic   valid_s2;
	rsp_t   rsp_s2;
	// architectural state
	logic [7:0] acc_q;
	flags_t     flags_q;

	logic   adv_s1;     // item in stage 1 moves to the result register
	rsp_t   exec_rsp;

	// stage 1 moves when the result register is empty or being drained
	assign adv_s1    = valid_s1 && (!valid_s2 || rsp_ready);
	// take a new item when stage 1 is empty or emptying this cycle
	assign req_ready = !valid_s1 || adv_s1;

	ealu_exec u_exec (
		.req (req_s1),
		.acc (acc_q),
		.flg (flags_q),
		.rsp (exec_rsp)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_s2 <= exec_rsp;
		end
	end

	// accumulator and flags commit as the item enters the result register,
	// so the next item in stage 1 already sees them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= 8'd0;
			flags_q <= '0;
		end else if (adv_s1) begin
			acc_q   <= exec_rsp.accumulator_out;
			flags_q <= '{z: exec_rsp.zero_flag, n: exec_rsp.subtract_flag,
				h: exec_rsp.half_carry_flag, c: exec_rsp.carry_flag};
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// shown accumulator, z and c flags always match the committed state
	a_rsp_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (rsp_s2.accumulator_out == acc_q) &&
			(rsp_s2.zero_flag == flags_q.z) && (rsp_s2.carry_flag == flags_q.c))
		else $error("result register out of step with accumulator or flags");

	// compare leaves the accumulator alone
	a_cp_keeps_acc: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (req_s1.cmd == CMD_CP) |=> acc_q == $past(acc_q))
		else $error("cp changed the accumulator");

	// 16-bit inc/dec touch no flags
	a_inc16_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && ((req_s1.cmd == CMD_INC16) || (req_s1.cmd == CMD_DEC16))
			|=> flags_q == $past(flags_q))
		else $error("16-bit inc/dec changed the flags");

endmodule

`default_nettype wire

// File: rtl/ealu_exec.sv
`default_nettype none

// one pass of the alu: current accumulator and flags plus one item in,
// result item (which also carries the next accumulator and flags) out
module ealu_exec (
	input  ealu_pkg::req_t   req,
	input  logic [7:0]       acc,
	input  ealu_pkg::flags_t flg,
	output ealu_pkg::rsp_t   rsp
);
	import ealu_pkg::*;

	logic        cin;
	logic [8:0]  sum9;
	logic [4:0]  nib5;
	logic [8:0]  diff9;
	logic [4:0]  ndiff5;
	logic [7:0]  inc8;
	logic [7:0]  dec8;
	logic [16:0] hl17;
	logic [12:0] hl13;
	logic [15:0] off16;
	logic [15:0] sp16;
	logic [4:0]  sph5;
	logic [8:0]  spc9;
	logic        daa_hi;
	logic        daa_lo;
	logic [7:0]  daa_a1;
	logic [7:0]  daa_a2;
	logic        daa_c;
	logic [7:0]  acc_n;
	logic [7:0]  byte_n;
	logic [15:0] word_n;
	flags_t      flg_n;

	// adders for all commands, computed ahead of the command select
	always_comb begin
		cin    = ((req.cmd == CMD_ADC) || (req.cmd == CMD_SBC)) ? flg.c : 1'b0;
		sum9   = {1'b0, acc} + {1'b0, req.byte_operand} + {8'd0, cin};
		nib5   = {1'b0, acc[3:0]} + {1'b0, req.byte_operand[3:0]} + {4'd0, cin};
		diff9  = {1'b0, acc} - {1'b0, req.byte_operand} - {8'd0, cin};
		ndiff5 = {1'b0, acc[3:0]} - {1'b0, req.byte_operand[3:0]} - {4'd0, cin};
		inc8   = req.byte_operand + 8'd1;
		dec8   = req.byte_operand - 8'd1;
		hl17   = {1'b0, req.word_base} + {1'b0, req.word_operand};
		hl13   = {1'b0, req.word_base[11:0]} + {1'b0, req.word_operand[11:0]};
		off16  = {{8{req.signed_offset[7]}}, req.signed_offset};
		sp16   = req.word_base + off16;
		sph5   = {1'b0, req.word_base[3:0]} + {1'b0, req.signed_offset[3:0]};
		spc9   = {1'b0, req.word_base[7:0]} + {1'b0, req.signed_offset[7:0]};
	end

	// decimal adjust
	always_comb begin
		daa_hi = 1'b0;
		daa_lo = 1'b0;
		daa_c  = flg.c;
		if (!flg.n) begin
			daa_hi = flg.c || (acc > BCD_MAX);
			daa_a1 = daa_hi ? acc + DAA_HI_ADJ : acc;
			daa_c  = flg.c | daa_hi;
			daa_lo = flg.h || (daa_a1[3:0] > DIGIT_MAX);
			daa_a2 = daa_lo ? daa_a1 + DAA_LO_ADJ : daa_a1;
		end else begin
			daa_a1 = flg.c ? acc - DAA_HI_ADJ : acc;
			daa_a2 = flg.h ? daa_a1 - DAA_LO_ADJ : daa_a1;
		end
	end

	always_comb begin
		acc_n  = acc;
		flg_n  = flg;
		byte_n = 8'd0;
		word_n = 16'd0;
		case (req.cmd)
			CMD_ADD, CMD_ADC: begin
				acc_n = sum9[7:0];
				flg_n = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: nib5[4], c: sum9[8]};
			end
			CMD_SUB, CMD_SBC, CMD_CP: begin
				if (req.cmd != CMD_CP) begin
					acc_n = diff9[7:0];
				end
				flg_n = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: ndiff5[4], c: diff9[8]};
			end
			CMD_AND: begin
				acc_n = acc & req.byte_operand;
				flg_n = '{z: ((acc & req.byte_operand) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			CMD_XOR: begin
				acc_n = acc ^ req.byte_operand;
				flg_n = '{z: ((acc ^ req.byte_operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			CMD_OR: begin
				acc_n = acc | req.byte_operand;
				flg_n = '{z: ((acc | req.byte_operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			CMD_INC8: begin
				byte_n  = inc8;
				flg_n.z = (inc8 == 8'd0);
				flg_n.n = 1'b0;
				flg_n.h = (inc8[3:0] == 4'h0);
			end
			CMD_DEC8: begin
				byte_n  = dec8;
				flg_n.z = (dec8 == 8'd0);
				flg_n.n = 1'b1;
				flg_n.h = (dec8[3:0] == 4'hF);
			end
			CMD_INC16: begin
				word_n = req.word_base + 16'd1;
			end
			CMD_DEC16: begin
				word_n = req.word_base - 16'd1;
			end
			CMD_DAA: begin
				acc_n   = daa_a2;
				flg_n.z = (daa_a2 == 8'd0);
				flg_n.h = 1'b0;
				flg_n.c = daa_c;
			end
			CMD_SCF: begin
				flg_n.n = 1'b0;
				flg_n.h = 1'b0;
				flg_n.c = 1'b1;
			end
			CMD_CPL: begin
				acc_n   = ~acc;
				flg_n.n = 1'b1;
				flg_n.h = 1'b1;
			end
			CMD_CCF: begin
				flg_n.n = 1'b0;
				flg_n.h = 1'b0;
				flg_n.c = ~flg.c;
			end
			CMD_ADDHL: begin
				word_n  = hl17[15:0];
				flg_n.n = 1'b0;
				flg_n.h = hl13[12];
				flg_n.c = hl17[16];
			end
			CMD_ADDSP: begin
				word_n = sp16;
				flg_n  = '{z: 1'b0, n: 1'b0, h: sph5[4], c: spc9[8]};
			end
			default: begin
				acc_n = acc;
			end
		endcase
	end

	always_comb begin
		rsp.accumulator_out = acc_n;
		rsp.byte_result     = byte_n;
		rsp.word_result     = word_n;
		rsp.zero_flag       = flg_n.z;
		rsp.subtract_flag   = flg_n.n;
		rsp.half_carry_flag = flg_n.h;
		rsp.carry_flag      = flg_n.c;
	end

endmodule

`default_nettype wire

// File: verif/eight_bit_alu_with_flags_tb.sv
module eight_bit_alu_with_flags_tb;
	import ealu_pkg::*;

	// codes past the last command, which the block must ignore
	localparam logic [4:0] CMD_UNKNOWN_LO = 5'd18;
	localparam logic [4:0] CMD_UNKNOWN_HI = 5'd31;

	localparam int RANDOM_ITEMS   = 420;
	localparam int FILL_ITEMS     = 30;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	// settle margin after the last pending result is checked
	localparam int DRAIN_SETTLE   = 6;

	typedef enum logic [1:0] {RX_FREE, RX_PATTERN, RX_HOLD} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// alu state as the block should hold it
	logic [7:0] model_acc;
	flags_t model_flags;
	rsp_t expected_results[$];

	int mismatch_count = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int stall_cycles = 0;
	int burst_left = 0;
	bit pace_gaps = 1'b1;

	// receiver behavior
	rx_mode_e rx_mode = RX_PATTERN;
	logic [7:0] rx_pattern = 8'hB6;
	logic [7:0] rx_tick = '0;
	int hold_cnt = 0;

	wire req_fire = req_valid && req_ready;
	wire rsp_fire = rsp_valid && rsp_ready;

	eight_bit_alu_with_flags uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// next accumulator, flags and result fields for one command
	function automatic rsp_t predict_alu_result(input req_t r);
		rsp_t res;
		logic [7:0] a, b, diff, off;
		logic [4:0] nib;
		logic [8:0] sum9;
		logic [12:0] sum13;
		logic [16:0] sum17;
		logic cin;
		res = '0;
		a = model_acc;
		b = r.byte_operand;
		off = r.signed_offset;
		cin = model_flags.c;
		case (r.cmd)
			CMD_ADD, CMD_ADC: begin
				if (r.cmd == CMD_ADD)
					cin = 1'b0;
				sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
				nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
				model_acc = sum9[7:0];
				model_flags = {sum9[7:0] == 8'd0, 1'b0, nib[4], sum9[8]};
			end
			CMD_SUB, CMD_SBC, CMD_CP: begin
				if (r.cmd != CMD_SBC)
					cin = 1'b0;
				diff = a - b - {7'd0, cin};
				model_flags = {diff == 8'd0, 1'b1,
					{1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cin}),
					{1'b0, a} < ({1'b0, b} + {8'd0, cin})};
				// compare only sets flags
				if (r.cmd != CMD_CP)
					model_acc = diff;
			end
			CMD_AND: begin
				model_acc = a & b;
				model_flags = {model_acc == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			CMD_XOR: begin
				model_acc = a ^ b;
				model_flags = {model_acc == 8'd0, 1'b0, 1'b0, 1'b0};
			end
			CMD_OR: begin
				model_acc = a | b;
				model_flags = {model_acc == 8'd0, 1'b0, 1'b0, 1'b0};
			end
			CMD_INC8: begin
				res.byte_result = b + 8'd1;
				model_flags = {res.byte_result == 8'd0, 1'b0,
					res.byte_result[3:0] == 4'h0, model_flags.c};
			end
			CMD_DEC8: begin
				res.byte_result = b - 8'd1;
				model_flags = {res.byte_result == 8'd0, 1'b1,
					res.byte_result[3:0] == 4'hF, model_flags.c};
			end
			CMD_INC16: res.word_result = r.word_base + 16'd1;
			CMD_DEC16: res.word_result = r.word_base - 16'd1;
			CMD_DAA: begin
				if (!model_flags.n) begin
					if (model_flags.c || a > BCD_MAX) begin
						a = a + DAA_HI_ADJ;
						model_flags.c = 1'b1;
					end
					if (model_flags.h || a[3:0] > DIGIT_MAX)
						a = a + DAA_LO_ADJ;
				end else begin
					if (model_flags.c)
						a = a - DAA_HI_ADJ;
					if (model_flags.h)
						a = a - DAA_LO_ADJ;
				end
				model_acc = a;
				model_flags.z = (a == 8'd0);
				model_flags.h = 1'b0;
			end
			CMD_SCF: begin
				model_flags.n = 1'b0;
				model_flags.h = 1'b0;
				model_flags.c = 1'b1;
			end
			CMD_CPL: begin
				model_acc = ~a;
				model_flags.n = 1'b1;
				model_flags.h = 1'b1;
			end
			CMD_CCF: begin
				model_flags.n = 1'b0;
				model_flags.h = 1'b0;
				model_flags.c = ~cin;
			end
			CMD_ADDHL: begin
				sum17 = {1'b0, r.word_base} + {1'b0, r.word_operand};
				sum13 = {1'b0, r.word_base[11:0]} + {1'b0, r.word_operand[11:0]};
				res.word_result = sum17[15:0];
				model_flags.n = 1'b0;
				model_flags.h = sum13[12];
				model_flags.c = sum17[16];
			end
			CMD_ADDSP: begin
				res.word_result = r.word_base + {{8{off[7]}}, off};
				nib = {1'b0, r.word_base[3:0]} + {1'b0, off[3:0]};
				sum9 = {1'b0, r.word_base[7:0]} + {1'b0, off};
				model_flags = {1'b0, 1'b0, nib[4], sum9[8]};
			end
			default: ;
		endcase
		res.accumulator_out = model_acc;
		res.zero_flag = model_flags.z;
		res.subtract_flag = model_flags.n;
		res.half_carry_flag = model_flags.h;
		res.carry_flag = model_flags.c;
		return res;
	endfunction

	function automatic req_t make_req(input logic [4:0] cmd, input logic [7:0] b,
			input logic [15:0] wb, input logic [15:0] wo, input logic [7:0] off);
		req_t r;
		r.cmd = cmd;
		r.byte_operand = b;
		r.word_base = wb;
		r.word_operand = wo;
		r.signed_offset = off;
		return r;
	endfunction

	// operands leaning toward carry and borrow edges
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return {4'($urandom), 4'hF};
			3: return {4'($urandom), 4'h0};
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {4'($urandom), 12'hFFF};
			3: return {8'($urandom), 8'hFF};
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %h, expected %h",
				results_checked, name, got, want));
	endtask

	// offer one item and hold it until taken; bursts and gaps handled here
	task automatic send_item(input req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = pace_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// stop offering and let every pending result come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	// receiver: free-running, rotating stall pattern, or one long hold-off
	always @(posedge clk) begin
		rx_tick <= rx_tick + 8'd1;
		case (rx_mode)
			RX_FREE: rsp_ready <= 1'b1;
			RX_PATTERN: begin
				rsp_ready <= rx_pattern[0];
				// new pattern when the low five tick bits wrap to zero, sometimes no stalls at all
				if (rx_tick[4:0] == 5'd0)
					rx_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF :
						(8'($urandom) | 8'h01);
				else
					rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
			end
			RX_HOLD: begin
				if (hold_cnt < HOLD_CYCLES) begin
					rsp_ready <= 1'b0;
					hold_cnt <= hold_cnt + 1;
				end else begin
					rsp_ready <= 1'b1;
				end
			end
			default: rsp_ready <= 1'b1;
		endcase
		if (rx_mode != RX_HOLD)
			hold_cnt <= 0;
	end

	// result check first, then the prediction for the item taken at this edge;
	// latency keeps those two from ever belonging together
	always @(posedge clk) begin : scoreboard
		rsp_t want;
		if (arst_n && rsp_fire) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with no item pending: acc=%h word=%h",
					rsp.accumulator_out, rsp.word_result));
			end else begin
				want = expected_results.pop_front();
				check_field("accumulator_out", 16'(rsp.accumulator_out),
					16'(want.accumulator_out));
				check_field("byte_result", 16'(rsp.byte_result), 16'(want.byte_result));
				check_field("word_result", rsp.word_result, want.word_result);
				check_field("zero_flag", 16'(rsp.zero_flag), 16'(want.zero_flag));
				check_field("subtract_flag", 16'(rsp.subtract_flag),
					16'(want.subtract_flag));
				check_field("half_carry_flag", 16'(rsp.half_carry_flag),
					16'(want.half_carry_flag));
				check_field("carry_flag", 16'(rsp.carry_flag), 16'(want.carry_flag));
				results_checked++;
			end
		end
		if (arst_n && req_fire) begin
			expected_results.push_back(predict_alu_result(req));
			items_accepted++;
		end
	end

	// watchdog: too long without any handshake on either side
	always @(posedge clk) begin
		if (req_fire || rsp_fire)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: %0d cycles without a handshake", stall_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// byte alu group at its extremes, starting from the reset state
	task automatic test_byte_alu();
		send_item(make_req(CMD_CP, 8'h00, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		send_item(make_req(CMD_ADC, 8'h01, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_SUB, 8'h01, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_SBC, 8'hFF, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_AND, 8'h0F, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_XOR, 8'hFF, 16'h0000, 16'h0000, 8'h00));
		// inc/dec across nibble and byte wrap, carry must survive
		send_item(make_req(CMD_INC8, 8'hFF, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_INC8, 8'h0F, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_DEC8, 8'h00, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_DEC8, 8'h10, 16'h0000, 16'h0000, 8'h00));
	endtask

	// word ops: wrap, carries from bit 11 and 15, most negative offset
	task automatic test_word_ops();
		send_item(make_req(CMD_INC16, 8'h00, 16'hFFFF, 16'h0000, 8'h00));
		send_item(make_req(CMD_DEC16, 8'h00, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_ADDHL, 8'h00, 16'hFFFF, 16'h0001, 8'h00));
		send_item(make_req(CMD_ADDHL, 8'h00, 16'h0FFF, 16'h0001, 8'h00));
		send_item(make_req(CMD_ADDSP, 8'h00, 16'hFFFF, 16'h0000, 8'h80));
		send_item(make_req(CMD_ADDSP, 8'h00, 16'h00FF, 16'h0000, 8'h7F));
	endtask

	// decimal adjust after add and after subtract, then the flag ops
	task automatic test_daa_and_flag_ops();
		send_item(make_req(CMD_AND, 8'h00, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_OR, 8'h45, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_ADD, 8'h38, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_DAA, 8'h00, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_SUB, 8'h19, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_DAA, 8'h00, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_SCF, 8'h00, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_CCF, 8'h00, 16'h0000, 16'h0000, 8'h00));
		send_item(make_req(CMD_CPL, 8'h00, 16'h0000, 16'h0000, 8'h00));
	endtask

	// codes past the table: state unchanged, unused results zero
	task automatic test_unknown_commands();
		send_item(make_req(CMD_UNKNOWN_LO, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		send_item(make_req(CMD_UNKNOWN_HI, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_fill_and_stall();
		rx_mode <= RX_HOLD;
		pace_gaps = 1'b0;
		repeat (FILL_ITEMS)
			send_item(make_req(5'($urandom_range(CMD_ADD, CMD_ADDSP)), pick_byte(),
				pick_word(), pick_word(), pick_byte()));
		wait_drained();
		rx_mode <= RX_PATTERN;
		pace_gaps = 1'b1;
	endtask

	// random commands, with bcd add/sub followed by daa to reach the
	// adjust paths, and some unknown codes as noise
	task automatic test_random_traffic();
		int sent;
		logic [4:0] cmd;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					cmd = 5'($urandom_range(CMD_ADD, CMD_SBC));
					send_item(make_req(cmd,
						{4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))},
						pick_word(), pick_word(), pick_byte()));
					send_item(make_req(CMD_DAA, pick_byte(), pick_word(), pick_word(),
						pick_byte()));
					sent += 2;
				end
				2: begin
					cmd = 5'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
					send_item(make_req(cmd, pick_byte(), pick_word(), pick_word(),
						pick_byte()));
					sent++;
				end
				default: begin
					cmd = 5'($urandom_range(CMD_ADD, CMD_ADDSP));
					send_item(make_req(cmd, pick_byte(), pick_word(), pick_word(),
						pick_byte()));
					sent++;
				end
			endcase
		end
		wait_drained();
	endtask

	initial begin
		model_acc = 8'h00;
		model_flags = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_byte_alu();
		test_word_ops();
		test_daa_and_flag_ops();
		test_unknown_commands();
		wait_drained();
		test_fill_and_stall();
		test_random_traffic();

		$display("run covered %0d items and %0d checked results over all 18 commands",
			items_accepted, results_checked);
		$display("plus unknown codes, bcd adjust chains, bursty input and a %0d-cycle hold",
			HOLD_CYCLES);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/ealu_pkg.sv
rtl/ealu_exec.sv
rtl/eight_bit_alu_with_flags.sv
verif/eight_bit_alu_with_flags_tb.sv
